// File: hdl/imm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer matrix multiply package
// Shared widths, codes and request/result types for the matrix multiplier.
// ----------------------------------------------------------------------------
package imm_pkg;

  localparam int MAX_DIM  = 8;
  localparam int DIM_W    = 3;               // bits of a row or column index
  localparam int SIZE_W   = 4;               // bits of a size register
  localparam int ADDR_W   = 2 * DIM_W;       // row * MAX_DIM + col
  localparam int DATA_W   = 32;
  localparam int DEPTH    = MAX_DIM * MAX_DIM;
  localparam int CFG_IDX_W = 2;

  localparam logic [SIZE_W-1:0] MAX_SIZE = SIZE_W'(MAX_DIM);

  localparam logic [1:0] OP_LOAD_A = 2'd0;
  localparam logic [1:0] OP_LOAD_B = 2'd1;
  localparam logic [1:0] OP_MULT   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS_OF_A  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_OF_B  = 2'd2;

  typedef struct packed {
    logic [1:0]              opcode;
    logic [DIM_W-1:0]        row_index;
    logic [DIM_W-1:0]        col_index;
    logic signed [DATA_W-1:0] element_value;
  } in_req_t;

  typedef struct packed {
    logic [DIM_W-1:0]        out_row;
    logic [DIM_W-1:0]        out_col;
    logic signed [DATA_W-1:0] product_value;
    logic                    last;
  } out_res_t;

  // Bookkeeping that travels with each multiply-accumulate step.
  typedef struct packed {
    logic             first;     // first term of a dot product
    logic             term_last; // last term of a dot product
    logic             zero;      // empty inner dimension, term is zero
    logic [DIM_W-1:0] row;
    logic [DIM_W-1:0] col;
    logic             last;      // final element of the run
  } mac_tag_t;

  // Saturate a size register to MAX_DIM.
  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v);
    eff_size = (v > MAX_SIZE) ? MAX_SIZE : v;
  endfunction

endpackage

// File: hdl/imm_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix element stores
// Two 64 x 32 synchronous memories for the left and right operands, one write
// port and one registered read port each.
// ----------------------------------------------------------------------------
module imm_store
  import imm_pkg::*;
(
  input  logic              clk,
  input  logic              we_a,
  input  logic              we_b,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr_a,
  input  logic [ADDR_W-1:0] raddr_b,
  output logic [DATA_W-1:0] rdata_a,
  output logic [DATA_W-1:0] rdata_b
);

  logic [DATA_W-1:0] left_mem  [DEPTH];
  logic [DATA_W-1:0] right_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we_a) begin
      left_mem[waddr] <= wdata;
    end
    rdata_a <= left_mem[raddr_a];
  end

  always_ff @(posedge clk) begin
    if (we_b) begin
      right_mem[waddr] <= wdata;
    end
    rdata_b <= right_mem[raddr_b];
  end

endmodule

// File: hdl/imm_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multiply-accumulate pipeline
// Aligns step tags with memory read data, multiplies, accumulates the dot
// product and registers each finished element as a one-cycle result.
// ----------------------------------------------------------------------------
module imm_mac
  import imm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              issue_valid,
  input  mac_tag_t          issue_tag,
  input  logic [DATA_W-1:0] rdata_a,
  input  logic [DATA_W-1:0] rdata_b,
  output logic              pipe_busy,
  output logic              out_valid,
  output out_res_t          out_data
);

  logic              s1_valid_r, s2_valid_r, out_valid_r;
  mac_tag_t          s1_tag_r, s2_tag_r;
  logic [DATA_W-1:0] prod_r, prod_nxt;
  logic [DATA_W-1:0] acc_r, acc_nxt;
  logic [DATA_W-1:0] low_prod;
  out_res_t          out_data_r;

  // Only the low word matters, so signedness of the operands is irrelevant.
  assign low_prod = rdata_a * rdata_b;
  assign prod_nxt = s1_tag_r.zero ? '0 : low_prod;
  assign acc_nxt  = s2_tag_r.first ? prod_r : acc_r + prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= issue_valid;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r && s2_tag_r.term_last;
    end
  end

  always_ff @(posedge clk) begin
    s1_tag_r <= issue_tag;
    s2_tag_r <= s1_tag_r;
    prod_r   <= prod_nxt;
    if (s2_valid_r) begin
      acc_r <= acc_nxt;
    end
    if (s2_valid_r && s2_tag_r.term_last) begin
      out_data_r.out_row       <= s2_tag_r.row;
      out_data_r.out_col       <= s2_tag_r.col;
      out_data_r.product_value <= acc_nxt;
      out_data_r.last          <= s2_tag_r.last;
    end
  end

  assign pipe_busy = s1_valid_r || s2_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: hdl/integer_matrix_multiply.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer matrix multiply
// Loads two signed 32-bit matrices into on-chip stores and emits their
// wrapped product row-major, one element per strobed result.
// A load request, an ignored request or a multiply with an empty product leaves
// busy low. Any other multiply issues one store read pair per cycle, m*p*max(n,1)
// pairs in all; busy then stays high while the pipeline drains and falls in the
// cycle that carries the final result. Each element is strobed once its last term
// has passed the store read, product and output registers, and results cannot be
// stalled. Synchronous active-low reset sets all sizes to 1.
// ----------------------------------------------------------------------------
module integer_matrix_multiply
  import imm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  in_req_t              in_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_data,
  output logic                 out_valid,
  output out_res_t             out_data
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t             state_r, state_nxt;
  logic [SIZE_W-1:0]  rows_r, inner_r, cols_r;
  logic [SIZE_W-1:0]  m_eff, n_eff, p_eff;
  logic [SIZE_W-1:0]  m_run_r, n_run_r, p_run_r;
  logic               zero_run_r;
  logic [DIM_W-1:0]   i_r, j_r, k_r, i_nxt, j_nxt, k_nxt;
  logic               k_end, j_end, i_end;
  logic               accept, load_ok_a, load_ok_b;
  logic               pipe_busy, issue_valid;
  mac_tag_t           issue_tag;
  logic [DATA_W-1:0]  rdata_a, rdata_b;
  logic [ADDR_W-1:0]  waddr;

  assign m_eff = eff_size(rows_r);
  assign n_eff = eff_size(inner_r);
  assign p_eff = eff_size(cols_r);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r  <= SIZE_W'(1);
      inner_r <= SIZE_W'(1);
      cols_r  <= SIZE_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ROWS_OF_A:  rows_r  <= cfg_data;
        REG_INNER_SIZE: inner_r <= cfg_data;
        REG_COLS_OF_B:  cols_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy   = (state_r != ST_IDLE) || pipe_busy;
  assign accept = start && !busy;

  assign load_ok_a = accept && (in_data.opcode == OP_LOAD_A)
                     && ({1'b0, in_data.row_index} < m_eff)
                     && ({1'b0, in_data.col_index} < n_eff);
  assign load_ok_b = accept && (in_data.opcode == OP_LOAD_B)
                     && ({1'b0, in_data.row_index} < n_eff)
                     && ({1'b0, in_data.col_index} < p_eff);
  assign waddr = {in_data.row_index, in_data.col_index};

  // Loop bounds: an empty inner dimension still runs one zero term.
  assign k_end = ({1'b0, k_r} + SIZE_W'(1)) == n_run_r;
  assign j_end = ({1'b0, j_r} + SIZE_W'(1)) == p_run_r;
  assign i_end = ({1'b0, i_r} + SIZE_W'(1)) == m_run_r;

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    unique case (state_r)
      ST_IDLE: begin
        i_nxt = '0;
        j_nxt = '0;
        k_nxt = '0;
        if (accept && (in_data.opcode == OP_MULT)
            && (m_eff != '0) && (p_eff != '0)) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (!k_end) begin
          k_nxt = k_r + DIM_W'(1);
        end else begin
          k_nxt = '0;
          if (!j_end) begin
            j_nxt = j_r + DIM_W'(1);
          end else begin
            j_nxt = '0;
            if (!i_end) begin
              i_nxt = i_r + DIM_W'(1);
            end else begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r <= i_nxt;
    j_r <= j_nxt;
    k_r <= k_nxt;
    if (state_r == ST_IDLE) begin
      m_run_r    <= m_eff;
      p_run_r    <= p_eff;
      n_run_r    <= (n_eff == '0) ? SIZE_W'(1) : n_eff;
      zero_run_r <= (n_eff == '0);
    end
  end

  assign issue_valid         = (state_r == ST_RUN);
  assign issue_tag.first     = (k_r == '0);
  assign issue_tag.term_last = k_end;
  assign issue_tag.zero      = zero_run_r;
  assign issue_tag.row       = i_r;
  assign issue_tag.col       = j_r;
  assign issue_tag.last      = k_end && j_end && i_end;

  imm_store u_store (
    .clk     (clk),
    .we_a    (load_ok_a),
    .we_b    (load_ok_b),
    .waddr   (waddr),
    .wdata   (in_data.element_value),
    .raddr_a ({i_r, k_r}),
    .raddr_b ({k_r, j_r}),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  imm_mac u_mac (
    .clk         (clk),
    .rst_n       (rst_n),
    .issue_valid (issue_valid),
    .issue_tag   (issue_tag),
    .rdata_a     (rdata_a),
    .rdata_b     (rdata_b),
    .pipe_busy   (pipe_busy),
    .out_valid   (out_valid),
    .out_data    (out_data)
  );

endmodule

// File: tb/tb_integer_matrix_multiply.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer matrix multiply testbench
// Loads both operand matrices through the request port, issues multiplies and
// checks every product element against a matrix model kept in the bench.
// Sizes change between phases, including zero and saturated sizes, and the
// sender's gaps differ from phase to phase.
// ----------------------------------------------------------------------------
module tb_integer_matrix_multiply;
  import imm_pkg::*;

  localparam int DIM = MAX_DIM;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  in_req_t              in_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [SIZE_W-1:0]    cfg_data;
  logic                 out_valid;
  out_res_t             out_data;

  // Bench copy of both matrices, which entries hold data, and the sizes.
  logic [DATA_W-1:0] left_mat  [DEPTH];
  logic [DATA_W-1:0] right_mat [DEPTH];
  bit                left_set  [DEPTH];
  bit                right_set [DEPTH];
  logic [SIZE_W-1:0] rows_reg;
  logic [SIZE_W-1:0] inner_reg;
  logic [SIZE_W-1:0] cols_reg;

  out_res_t pending_products[$];
  int       requests_sent    = 0;
  int       products_checked = 0;
  int       mismatch_count   = 0;
  int       sender_idle_pct  = 0;

  integer_matrix_multiply i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  always #6 clk = ~clk;

  function automatic int clamp_dim(input logic [SIZE_W-1:0] v);
    return (v > DIM) ? DIM : int'(v);
  endfunction

  function automatic in_req_t make_req(input logic [1:0] op, input int row, input int col,
                                       input logic [DATA_W-1:0] val);
    in_req_t req;
    req.opcode        = op;
    req.row_index     = DIM_W'(row);
    req.col_index     = DIM_W'(col);
    req.element_value = val;
    return req;
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'hFFFF_FFFF;
      3:       return $urandom_range(15);
      default: return $urandom;
    endcase
  endfunction

  // Mostly small sizes; now and then empty, full or above the maximum.
  function automatic logic [SIZE_W-1:0] pick_size();
    int roll;
    roll = $urandom_range(99);
    if (roll < 5)  return '0;
    if (roll < 12) return SIZE_W'(DIM);
    if (roll < 18) return SIZE_W'($urandom_range(9, 15));
    return SIZE_W'($urandom_range(1, 4));
  endfunction

  // Every element of the product, row-major, as 32-bit wrapped dot products.
  function automatic void queue_products();
    int m, n, p;
    logic [DATA_W-1:0] acc;
    out_res_t elem;
    m = clamp_dim(rows_reg);
    n = clamp_dim(inner_reg);
    p = clamp_dim(cols_reg);
    for (int i = 0; i < m; i++) begin
      for (int j = 0; j < p; j++) begin
        acc = '0;
        for (int k = 0; k < n; k++) begin
          acc = acc + left_mat[i*DIM+k] * right_mat[k*DIM+j];
        end
        elem.out_row       = DIM_W'(i);
        elem.out_col       = DIM_W'(j);
        elem.product_value = acc;
        elem.last          = (i == m - 1) && (j == p - 1);
        pending_products.push_back(elem);
      end
    end
  endfunction

  function automatic void apply_to_matrices(input in_req_t req);
    int m, n, p, r, c;
    m = clamp_dim(rows_reg);
    n = clamp_dim(inner_reg);
    p = clamp_dim(cols_reg);
    r = int'(req.row_index);
    c = int'(req.col_index);
    case (req.opcode)
      OP_LOAD_A: begin
        if (r < m && c < n) begin
          left_mat[r*DIM+c] = req.element_value;
          left_set[r*DIM+c] = 1'b1;
        end
      end
      OP_LOAD_B: begin
        if (r < n && c < p) begin
          right_mat[r*DIM+c] = req.element_value;
          right_set[r*DIM+c] = 1'b1;
        end
      end
      OP_MULT: queue_products();
      default: ;
    endcase
  endfunction

  function automatic void note_mismatch(input string what, input logic [DATA_W-1:0] want,
                                        input logic [DATA_W-1:0] got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t: mismatch in %s: expected %0h, got %0h", $realtime, what, want, got);
    end
  endfunction

  always @(posedge clk) begin : check_products
    out_res_t want;
    if (rst_n && out_valid) begin
      if (pending_products.size() == 0) begin
        note_mismatch("unexpected result value", '0, out_data.product_value);
      end else begin
        want = pending_products.pop_front();
        products_checked++;
        if (out_data.out_row !== want.out_row)
          note_mismatch("out_row", DATA_W'(want.out_row), DATA_W'(out_data.out_row));
        if (out_data.out_col !== want.out_col)
          note_mismatch("out_col", DATA_W'(want.out_col), DATA_W'(out_data.out_col));
        if (out_data.product_value !== want.product_value)
          note_mismatch("product_value", want.product_value, out_data.product_value);
        if (out_data.last !== want.last)
          note_mismatch("last", DATA_W'(want.last), DATA_W'(out_data.last));
      end
    end
  end

  // Start is left high on return so that a following request goes out
  // back to back; anything that waits must lower it first.
  task automatic send_request(input in_req_t req);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (busy) @(posedge clk);
    apply_to_matrices(req);
    requests_sent++;
  endtask

  task automatic go_quiet();
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_products();
    go_quiet();
    while (pending_products.size() != 0 || busy) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_ROWS_OF_A:  rows_reg  = val;
      REG_INNER_SIZE: inner_reg = val;
      REG_COLS_OF_B:  cols_reg  = val;
      default: ;
    endcase
  endtask

  task automatic program_sizes(input logic [SIZE_W-1:0] rows, input logic [SIZE_W-1:0] inner,
                               input logic [SIZE_W-1:0] cols, input bit poke_spare);
    drain_products();
    // A multiply with an empty product issues no terms into the pipeline.
    repeat (4) @(posedge clk);
    if (poke_spare) write_reg(REG_SPARE, SIZE_W'($urandom));
    write_reg(REG_ROWS_OF_A, rows);
    write_reg(REG_INNER_SIZE, inner);
    write_reg(REG_COLS_OF_B, cols);
    cfg_valid <= 1'b0;
  endtask

  // Loads every entry the multiply will read that holds no data yet, then
  // issues the multiply with random don't-care fields.
  task automatic multiply_loaded();
    int m, n, p;
    m = clamp_dim(rows_reg);
    n = clamp_dim(inner_reg);
    p = clamp_dim(cols_reg);
    for (int r = 0; r < m; r++) begin
      for (int c = 0; c < n; c++) begin
        if (!left_set[r*DIM+c]) send_request(make_req(OP_LOAD_A, r, c, pick_value()));
      end
    end
    for (int r = 0; r < n; r++) begin
      for (int c = 0; c < p; c++) begin
        if (!right_set[r*DIM+c]) send_request(make_req(OP_LOAD_B, r, c, pick_value()));
      end
    end
    send_request(make_req(OP_MULT, $urandom, $urandom, $urandom));
  endtask

  function automatic in_req_t random_load(input int m, input int n, input int p);
    int roll;
    roll = $urandom_range(99);
    if (roll < 43 && m > 0 && n > 0)
      return make_req(OP_LOAD_A, $urandom_range(m - 1), $urandom_range(n - 1), pick_value());
    if (roll < 86 && n > 0 && p > 0)
      return make_req(OP_LOAD_B, $urandom_range(n - 1), $urandom_range(p - 1), pick_value());
    if (roll < 93)
      return make_req(OP_UNUSED, $urandom, $urandom, $urandom);
    // Anywhere in the index space, so often outside the current sizes.
    return make_req(($urandom_range(1) != 0) ? OP_LOAD_A : OP_LOAD_B,
                    $urandom_range(7), $urandom_range(7), pick_value());
  endfunction

  task automatic test_power_on_sizes();
    // Most negative times minus one wraps back to the most negative value.
    send_request(make_req(OP_LOAD_A, 0, 0, 32'h8000_0000));
    send_request(make_req(OP_LOAD_B, 0, 0, 32'hFFFF_FFFF));
    multiply_loaded();
  endtask

  task automatic test_wrapping_sums();
    program_sizes(4'd2, 4'd2, 4'd1, 1'b1);
    send_request(make_req(OP_LOAD_A, 0, 0, 32'h7FFF_FFFF));
    send_request(make_req(OP_LOAD_A, 0, 1, 32'h7FFF_FFFF));
    send_request(make_req(OP_LOAD_A, 1, 0, 32'hFFFF_FFFF));
    send_request(make_req(OP_LOAD_A, 1, 1, 32'h8000_0000));
    send_request(make_req(OP_LOAD_B, 0, 0, 32'h7FFF_FFFF));
    send_request(make_req(OP_LOAD_B, 1, 0, 32'h8000_0000));
    multiply_loaded();
  endtask

  task automatic test_ignored_requests();
    // None of these may change the stores, so the product must repeat.
    send_request(make_req(OP_LOAD_A, 7, 7, 32'h1234_5678));
    send_request(make_req(OP_LOAD_B, 7, 7, 32'h1234_5678));
    send_request(make_req(OP_LOAD_A, 0, 2, 32'h0BAD_0BAD));
    send_request(make_req(OP_LOAD_B, 2, 0, 32'h0BAD_0BAD));
    send_request(make_req(OP_UNUSED, 7, 7, 32'hFFFF_FFFF));
    multiply_loaded();
  endtask

  task automatic test_empty_inner();
    // Rows above the maximum saturate to eight; no inner terms gives zeros.
    program_sizes(4'd15, 4'd0, 4'd3, 1'b0);
    send_request(make_req(OP_LOAD_A, 7, 0, 32'h5555_AAAA));
    multiply_loaded();
  endtask

  task automatic test_empty_product();
    program_sizes(4'd0, 4'd0, 4'd15, 1'b0);
    multiply_loaded();
    program_sizes(4'd2, 4'd2, 4'd0, 1'b0);
    multiply_loaded();
  endtask

  task automatic run_random_phase(input int item_goal, input int idle_pct);
    int stop_at, rounds, loads, m, n, p;
    bit paused;
    sender_idle_pct = idle_pct;
    stop_at = requests_sent + item_goal;
    paused = 1'b0;
    while (requests_sent < stop_at) begin
      program_sizes(pick_size(), pick_size(), pick_size(), $urandom_range(3) == 0);
      m = clamp_dim(rows_reg);
      n = clamp_dim(inner_reg);
      p = clamp_dim(cols_reg);
      rounds = $urandom_range(1, 4);
      for (int rd = 0; rd < rounds && requests_sent < stop_at; rd++) begin
        loads = $urandom_range(2, 16);
        for (int l = 0; l < loads; l++) send_request(random_load(m, n, p));
        multiply_loaded();
        if (!paused || $urandom_range(7) == 0) begin
          drain_products();
          paused = 1'b1;
        end
      end
    end
  endtask

  initial begin : main_sequence
    int guard;
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    rows_reg  = 4'd1;
    inner_reg = 4'd1;
    cols_reg  = 4'd1;
    for (int e = 0; e < DEPTH; e++) begin
      left_mat[e]  = '0;
      right_mat[e] = '0;
      left_set[e]  = 1'b0;
      right_set[e] = 1'b0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    sender_idle_pct = 26;
    test_power_on_sizes();
    test_wrapping_sums();
    test_ignored_requests();
    test_empty_inner();
    test_empty_product();

    run_random_phase(137, 26);
    run_random_phase(137, 82);
    run_random_phase(136, 0);

    go_quiet();
    guard = 0;
    while ((pending_products.size() != 0 || busy) && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (10) @(posedge clk);
    if (pending_products.size() != 0) begin
      mismatch_count += pending_products.size();
      $display("%0d product elements never arrived", pending_products.size());
    end
    $display("Sent %0d requests over three sender-gap phases; checked %0d product elements,",
             requests_sent, products_checked);
    $display("with sizes from empty through saturated registers and wrapping sums.");
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin : watchdog
    #(10_000_000);
    $display("Timeout: the multiplier stopped making progress");
    $display("FAILURE");
    $finish;
  end

endmodule
